// ===== src/cctb_pkg.sv =====
// Shared constants and handshake types for the cycle counter time breakdown.
// Used by cctb_div and cycle_counter_time_breakdown; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cctb_pkg;

   parameter int SAMPLE_W   = 32;
   parameter int FREQ_W     = 10;
   parameter int CYCLES_W   = 64;
   parameter int SEC_W      = 32;
   parameter int FRAC_W     = 10;
   // divisor width covers the ticks per second at the highest rate
   parameter int DIVISOR_W  = 30;
   parameter int BITS_PER_STEP = 2;
   parameter int DIV_STEPS  = CYCLES_W / BITS_PER_STEP;
   parameter int STEP_CNT_W = $clog2(DIV_STEPS);

   parameter int FREQ_RESET = 550;
   parameter int US_PER_MS  = 1000;
   parameter int US_PER_S   = 1000000;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

// ===== src/cctb_div.sv =====
// Shared restoring divider: 64-bit dividend by a 30-bit divisor, two quotient
// bits per cycle. Depends on cctb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cctb_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cctb_pkg::div_ctl_type          ctl,
   input  wire logic [cctb_pkg::CYCLES_W-1:0]  dividend,
   input  wire logic [cctb_pkg::DIVISOR_W-1:0] divisor,
   output      cctb_pkg::div_sts_type          sts,
   output      logic [cctb_pkg::CYCLES_W-1:0]  quotient,
   output      logic [cctb_pkg::DIVISOR_W-1:0] remainder
);

   logic [cctb_pkg::CYCLES_W-1:0]   quo_ff, quo_in;
   logic [cctb_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [cctb_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [cctb_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   // quotient bits shift in at the bottom as the dividend shifts out the top
   always_comb begin
      logic [cctb_pkg::DIVISOR_W:0]   trial;
      logic [cctb_pkg::DIVISOR_W-1:0] r;
      logic [cctb_pkg::CYCLES_W-1:0]  q;
      r = rem_ff;
      q = quo_ff;
      trial = '0;
      for (int i = 0; i < cctb_pkg::BITS_PER_STEP; i++) begin
         trial = {r, q[cctb_pkg::CYCLES_W-1]};
         q = {q[cctb_pkg::CYCLES_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
            q[0] = 1'b1;
         end
         r = trial[cctb_pkg::DIVISOR_W-1:0];
      end

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cctb_pkg::STEP_CNT_W'(cctb_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/cycle_counter_time_breakdown.sv =====
// Cycle counter time breakdown: wrap extension of a 32-bit counter sample and
// split of the 64-bit count into seconds, millis, micros and total micros.
// Each request runs four passes of the shared two-bit-per-cycle divider, then
// one output load. A new request is taken only in idle, after the last result is
// loaded; a waiting result blocks requests only once the next result is ready.
// Reset (synchronous): state and wraps zero, 550 MHz.
`timescale 1ns / 1ps
`default_nettype none

module cycle_counter_time_breakdown (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [cctb_pkg::FREQ_W-1:0]   csr_wr_data,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [cctb_pkg::SAMPLE_W-1:0] req_counter_sample,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [cctb_pkg::SEC_W-1:0]    rsp_seconds,
   output      logic [cctb_pkg::FRAC_W-1:0]   rsp_millis,
   output      logic [cctb_pkg::FRAC_W-1:0]   rsp_micros,
   output      logic [cctb_pkg::CYCLES_W-1:0] rsp_total_us
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TICK,
      ST_DIV_SEC,
      ST_DIV_MS,
      ST_DIV_US,
      ST_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [cctb_pkg::FREQ_W-1:0]     freq_ff, freq_in;
   logic [cctb_pkg::SAMPLE_W-1:0]   last_ff, last_in;
   logic [cctb_pkg::SAMPLE_W-1:0]   wrap_ff, wrap_in;
   logic                            zero_ff, zero_in;
   logic [cctb_pkg::CYCLES_W-1:0]   total_ff, total_in;
   logic [cctb_pkg::FRAC_W-1:0]     micros_ff, micros_in;
   logic [cctb_pkg::FRAC_W-1:0]     millis_ff, millis_in;
   logic [cctb_pkg::SEC_W-1:0]      sec_ff, sec_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cctb_pkg::SEC_W-1:0]      rsp_sec_ff, rsp_sec_in;
   logic [cctb_pkg::FRAC_W-1:0]     rsp_ms_ff, rsp_ms_in;
   logic [cctb_pkg::FRAC_W-1:0]     rsp_us_ff, rsp_us_in;
   logic [cctb_pkg::CYCLES_W-1:0]   rsp_tot_ff, rsp_tot_in;

   logic                            accept;
   logic [cctb_pkg::DIVISOR_W-1:0]  tpus;
   logic [cctb_pkg::DIVISOR_W-1:0]  tpms;
   logic [cctb_pkg::DIVISOR_W-1:0]  tps;
   cctb_pkg::div_ctl_type           div_ctl;
   cctb_pkg::div_sts_type           div_sts;
   logic [cctb_pkg::CYCLES_W-1:0]   div_dividend;
   logic [cctb_pkg::DIVISOR_W-1:0]  div_divisor;
   logic [cctb_pkg::CYCLES_W-1:0]   div_quo;
   logic [cctb_pkg::DIVISOR_W-1:0]  div_rem;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // ticks per microsecond, millisecond and second at the current rate
   assign tpus = cctb_pkg::DIVISOR_W'(freq_ff);
   assign tpms = tpus * cctb_pkg::DIVISOR_W'(cctb_pkg::US_PER_MS);
   assign tps  = tpus * cctb_pkg::DIVISOR_W'(cctb_pkg::US_PER_S);

   cctb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      freq_in      = freq_ff;
      last_in      = last_ff;
      wrap_in      = wrap_ff;
      zero_in      = zero_ff;
      total_in     = total_ff;
      micros_in    = micros_ff;
      millis_in    = millis_ff;
      sec_in       = sec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_ms_in    = rsp_ms_ff;
      rsp_us_in    = rsp_us_ff;
      rsp_tot_in   = rsp_tot_ff;
      div_ctl.start = 1'b0;
      div_divisor  = tpus;
      div_dividend = {wrap_ff, last_ff};

      if (csr_wr_en) begin
         freq_in = csr_wr_data;
      end

      // drop the delivered result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_counter_sample < last_ff) begin
               wrap_in = wrap_ff + 1'b1;
            end
            div_dividend = {wrap_in, req_counter_sample};
            div_divisor  = tpus;
            if (accept) begin
               last_in  = req_counter_sample;
               zero_in  = (freq_ff == '0);
               div_ctl.start = 1'b1;
               state_in = ST_DIV_TICK;
            end else begin
               wrap_in = wrap_ff;
            end
         end
         ST_DIV_TICK: begin
            // cycles / ticks per microsecond gives total micros
            if (div_sts.done) begin
               total_in      = div_quo;
               div_dividend  = {wrap_ff, last_ff};
               div_divisor   = tps;
               div_ctl.start = 1'b1;
               state_in      = ST_DIV_SEC;
            end
         end
         ST_DIV_SEC: begin
            if (div_sts.done) begin
               sec_in        = div_quo[cctb_pkg::SEC_W-1:0];
               div_dividend  = cctb_pkg::CYCLES_W'(div_rem);
               div_divisor   = tpms;
               div_ctl.start = 1'b1;
               state_in      = ST_DIV_MS;
            end
         end
         ST_DIV_MS: begin
            if (div_sts.done) begin
               millis_in     = div_quo[cctb_pkg::FRAC_W-1:0];
               div_dividend  = cctb_pkg::CYCLES_W'(div_rem);
               div_divisor   = tpus;
               div_ctl.start = 1'b1;
               state_in      = ST_DIV_US;
            end
         end
         ST_DIV_US: begin
            if (div_sts.done) begin
               micros_in = div_quo[cctb_pkg::FRAC_W-1:0];
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sec_in   = zero_ff ? '0 : sec_ff;
               rsp_ms_in    = zero_ff ? '0 : millis_ff;
               rsp_us_in    = zero_ff ? '0 : micros_ff;
               rsp_tot_in   = zero_ff ? '0 : total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      zero_ff    <= zero_in;
      total_ff   <= total_in;
      micros_ff  <= micros_in;
      millis_ff  <= millis_in;
      sec_ff     <= sec_in;
      rsp_sec_ff <= rsp_sec_in;
      rsp_ms_ff  <= rsp_ms_in;
      rsp_us_ff  <= rsp_us_in;
      rsp_tot_ff <= rsp_tot_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         freq_ff      <= cctb_pkg::FREQ_W'(cctb_pkg::FREQ_RESET);
         last_ff      <= '0;
         wrap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         last_ff      <= last_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_seconds  = rsp_sec_ff;
   assign rsp_millis   = rsp_ms_ff;
   assign rsp_micros   = rsp_us_ff;
   assign rsp_total_us = rsp_tot_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for cycle_counter_time_breakdown: feeds counter samples with random idling,
// back-pressure and rate changes, predicts each time breakdown and checks every field.
// Depends on cctb_pkg and the cycle_counter_time_breakdown RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 600;
   localparam int PRESSURE_AT  = 290;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 80;
   localparam int STEADY_FIRST = 100;
   localparam int STEADY_LAST  = 180;

   typedef struct {
      logic [cctb_pkg::SEC_W-1:0]    seconds;
      logic [cctb_pkg::FRAC_W-1:0]   millis;
      logic [cctb_pkg::FRAC_W-1:0]   micros;
      logic [cctb_pkg::CYCLES_W-1:0] total_us;
   } breakdown_type;

   class breakdown_checker;
      logic [cctb_pkg::FREQ_W-1:0]   rate_mhz;
      logic [cctb_pkg::SAMPLE_W-1:0] prev_sample;
      logic [31:0]                   wraps;
      breakdown_type                 pending_breakdowns[$];
      int                            errors;

      function new();
         rate_mhz    = cctb_pkg::FREQ_W'(cctb_pkg::FREQ_RESET);
         prev_sample = '0;
         wraps       = '0;
         errors      = 0;
      endfunction

      function void set_rate(input logic [cctb_pkg::FREQ_W-1:0] rate);
         rate_mhz = rate;
      endfunction

      function int pending();
         return pending_breakdowns.size();
      endfunction

      function breakdown_type predict_breakdown(input logic [cctb_pkg::SAMPLE_W-1:0] sample);
         breakdown_type b;
         logic [63:0]   cycles, per_us, per_ms, per_s, whole_s, rem, ms, us;
         if (sample < prev_sample) begin
            wraps = wraps + 1;
         end
         prev_sample = sample;
         cycles     = {wraps, sample};
         b.seconds  = '0;
         b.millis   = '0;
         b.micros   = '0;
         b.total_us = '0;
         if (rate_mhz != '0) begin
            per_us     = {54'd0, rate_mhz};
            per_ms     = per_us * 64'd1000;
            per_s      = per_us * 64'd1000000;
            whole_s    = cycles / per_s;
            rem        = cycles % per_s;
            ms         = rem / per_ms;
            us         = (rem % per_ms) / per_us;
            b.seconds  = whole_s[cctb_pkg::SEC_W-1:0];
            b.millis   = ms[cctb_pkg::FRAC_W-1:0];
            b.micros   = us[cctb_pkg::FRAC_W-1:0];
            b.total_us = cycles / per_us;
         end
         return b;
      endfunction

      function void note_sample(input logic [cctb_pkg::SAMPLE_W-1:0] sample);
         pending_breakdowns.push_back(predict_breakdown(sample));
      endfunction

      task report(input string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_breakdown(input logic [cctb_pkg::SEC_W-1:0] seconds,
                           input logic [cctb_pkg::FRAC_W-1:0] millis,
                           input logic [cctb_pkg::FRAC_W-1:0] micros,
                           input logic [cctb_pkg::CYCLES_W-1:0] total_us);
         breakdown_type want;
         if (pending_breakdowns.size() == 0) begin
            report($sformatf("unexpected result, seconds %0d total_us %0d", seconds, total_us));
            return;
         end
         want = pending_breakdowns.pop_front();
         if (seconds !== want.seconds)
            report($sformatf("seconds %0d, want %0d", seconds, want.seconds));
         if (millis !== want.millis)
            report($sformatf("millis %0d, want %0d", millis, want.millis));
         if (micros !== want.micros)
            report($sformatf("micros %0d, want %0d", micros, want.micros));
         if (total_us !== want.total_us)
            report($sformatf("total_us %0d, want %0d", total_us, want.total_us));
      endtask
   endclass

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [cctb_pkg::FREQ_W-1:0]   csr_wr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [cctb_pkg::SAMPLE_W-1:0] req_counter_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [cctb_pkg::SEC_W-1:0]    rsp_seconds;
   logic [cctb_pkg::FRAC_W-1:0]   rsp_millis;
   logic [cctb_pkg::FRAC_W-1:0]   rsp_micros;
   logic [cctb_pkg::CYCLES_W-1:0] rsp_total_us;

   breakdown_checker board;
   bit               steady = 1'b0;
   int               requests_taken = 0;

   cycle_counter_time_breakdown i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_counter_sample (req_counter_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_seconds        (rsp_seconds),
      .rsp_millis         (rsp_millis),
      .rsp_micros         (rsp_micros),
      .rsp_total_us       (rsp_total_us)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watch every handshake; results are checked before the new request is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            board.set_rate(csr_wr_data);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_breakdown(rsp_seconds, rsp_millis, rsp_micros, rsp_total_us);
         end
         if (req_valid && !req_stall) begin
            board.note_sample(req_counter_sample);
            requests_taken++;
         end
      end
   end

   // Offer one request, idling first now and then; return at the accepting edge.
   task automatic send_sample(input logic [cctb_pkg::SAMPLE_W-1:0] sample);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_counter_sample <= sample;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [cctb_pkg::FREQ_W-1:0] rate);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rate;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [cctb_pkg::SAMPLE_W-1:0] advance_counter(
         input logic [cctb_pkg::SAMPLE_W-1:0] now);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35)      return now + $urandom_range(0, 2000);
      else if (pick < 60) return now + $urandom_range(0, 50_000_000);
      else if (pick < 80) return now + $urandom;
      else if (pick < 92) return $urandom;
      else if (pick < 96) return now;
      else                return now - 1;
   endfunction

   initial begin
      logic [cctb_pkg::SAMPLE_W-1:0] counter_now;
      logic [cctb_pkg::FREQ_W-1:0]   rate;
      int                            item;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset rate, counter edges and the first wrap
      send_sample(32'd0);         send_sample(32'd1);
      send_sample(32'd549999999); send_sample(32'd550000000);
      send_sample(32'hFFFF_FFFF); send_sample(32'd0);
      send_sample(32'd1);
      // slowest clock: second and millisecond boundaries
      write_rate(10'd1);
      send_sample(32'd999);       send_sample(32'd1000);
      send_sample(32'd999999);    send_sample(32'd1000000);
      send_sample(32'hFFFF_FFFF); send_sample(32'd5);
      // rate above 1000, equal samples do not count a wrap
      write_rate(10'd1023);
      send_sample(32'h8000_0000); send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF); send_sample(32'hFFFF_FFFE);
      // zero rate zeroes the result but still tracks wraps
      write_rate(10'd0);
      send_sample(32'd3);         send_sample(32'hFFFF_FFFF);
      send_sample(32'd0);
      write_rate(10'd1000);
      send_sample(32'hAAAA_AAAA); send_sample(32'h5555_5555);

      counter_now = 32'h5555_5555;
      item = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: rate = 10'd1000;
            1: rate = cctb_pkg::FREQ_W'($urandom_range(1, 1023));
            2: rate = 10'd1;
            3: rate = 10'd1023;
            default: rate = cctb_pkg::FREQ_W'($urandom_range(2, 999));
         endcase
         write_rate(rate);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            steady      = (item >= STEADY_FIRST) && (item < STEADY_LAST);
            counter_now = advance_counter(counter_now);
            send_sample(counter_now);
            item++;
         end
      end
      steady = 1'b0;

      wait_drained();
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off so the block backs up.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && requests_taken >= PRESSURE_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(99) < 20);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
